// ===== hdl/fixed_width_bit_packer_defines.svh =====
// ---------------------------------------------------------------------------
// Fixed-width bit packer assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef FIXED_WIDTH_BIT_PACKER_DEFINES_SVH
`define FIXED_WIDTH_BIT_PACKER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FWBP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fwbp check failed");
`define FWBP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("fwbp check failed");
`else
`define FWBP_ASSERT(lbl, prop)
`define FWBP_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== hdl/fwbp_pkg.sv =====
// ---------------------------------------------------------------------------
// fwbp_pkg
// Types and constants shared by the fixed-width bit packer modules.
// ---------------------------------------------------------------------------
package fwbp_pkg;

  localparam int unsigned MaxValueBitsDefault = 32;
  localparam int unsigned DataW       = 32;  // data_value and limit register width
  localparam int unsigned CapW        = 16;
  localparam int unsigned CursorW     = 19;
  localparam int unsigned PartialW    = 7;
  localparam int unsigned AccW        = PartialW + DataW;
  localparam int unsigned MaxBytes    = 4;
  localparam int unsigned ByteSelW    = $clog2(MaxBytes);
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned ResetWidth  = 8;   // bit length of the reset limit 255
  localparam logic [CapW-1:0] ResetCapacity = 16'd4096;

  typedef enum logic [1:0] {
    OpWrite   = 2'd0,
    OpEnd     = 2'd1,
    OpRestart = 2'd2
  } op_e;

  localparam logic [CfgIdxW-1:0] RegMaxValue = 1'd0;
  localparam logic [CfgIdxW-1:0] RegCapacity = 1'd1;

  typedef struct packed {
    logic [1:0]       operation;
    logic [DataW-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic [CapW-1:0] byte_index;
    logic            is_last;
    logic            overflow_error;
  } out_item_t;

  // One request's worth of result bytes, handed from front to back
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [ByteSelW-1:0]      last_sel;
    logic [CapW-1:0]          base_index;
    logic                     err;
  } job_t;

endpackage

// ===== hdl/fwbp_queue.sv =====
// ---------------------------------------------------------------------------
// fwbp_queue
// Short job queue between the request front end and the byte emitter.
// ---------------------------------------------------------------------------
`include "fixed_width_bit_packer_defines.svh"

module fwbp_queue import fwbp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t pop_job_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QueueDepth);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(QueueDepth - 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o    = (count_q == DepthCnt);
  assign valid_o   = (count_q != '0);
  assign pop_job_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  `FWBP_ASSERT_NEVER(a_push_when_full, push_i && count_q == DepthCnt)
  `FWBP_ASSERT_NEVER(a_pop_when_empty, pop_i && count_q == '0)

endmodule

// ===== hdl/fwbp_front.sv =====
// ---------------------------------------------------------------------------
// fwbp_front
// Takes requests, holds the configuration and the stream cursor, and turns
// requests into jobs of completed bytes or overflow reports.
// ---------------------------------------------------------------------------
`include "fixed_width_bit_packer_defines.svh"

module fwbp_front import fwbp_pkg::*; #(
  parameter int unsigned MaxValueBits = MaxValueBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_i,
  output logic               push_o,
  output job_t               job_o,
  input  logic               full_i
);

  localparam int unsigned WidthW = $clog2(MaxValueBits + 1);
  localparam logic [WidthW-1:0] WidthMax = WidthW'(MaxValueBits);
  localparam logic [WidthW-1:0] WidthRst =
    WidthW'((ResetWidth < MaxValueBits) ? ResetWidth : MaxValueBits);
  localparam int unsigned LenW = $clog2(DataW + 1);

  logic [WidthW-1:0]   width_q;
  logic [CapW-1:0]     cap_q;
  logic [CursorW-1:0]  cursor_q, cursor_d;
  logic [PartialW-1:0] partial_q, partial_d;

  logic [LenW-1:0]     bit_len;
  logic [WidthW-1:0]   width_new;
  logic                accept;
  logic [2:0]          fill;
  logic [CursorW:0]    end_pos;
  logic [CursorW:0]    round_pos;
  logic                wr_refuse;
  logic                end_refuse;
  logic                end_taken;
  logic [DataW-1:0]    rev;
  logic [DataW-1:0]    val;
  logic [LenW-1:0]     rsh;
  logic [AccW-1:0]     acc;
  logic [AccW-1:0]     acc_rest;
  logic [LenW-1:0]     total;
  logic [2:0]          nbytes;
  job_t                err_job;

  // bit length of the new limit value, capped and at least one
  always_comb begin
    bit_len = '0;
    for (int i = 0; i < DataW; i++) begin
      if (cfg_wdata_i[i]) begin
        bit_len = LenW'(i + 1);
      end
    end
    if (bit_len == '0) begin
      width_new = WidthW'(1);
    end else if (bit_len > LenW'(MaxValueBits)) begin
      width_new = WidthMax;
    end else begin
      width_new = WidthW'(bit_len);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthRst;
      cap_q   <= ResetCapacity;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMaxValue: width_q <= width_new;
        RegCapacity: cap_q   <= cfg_wdata_i[CapW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign fill       = cursor_q[2:0];

  assign end_pos    = {1'b0, cursor_q} + (CursorW + 1)'(width_q);
  assign round_pos  = {1'b0, cursor_q} + (CursorW + 1)'(7);
  assign wr_refuse  = !(end_pos[CursorW:3] < (CursorW - 2)'(cap_q));
  assign end_refuse = round_pos[CursorW:3] > (CursorW - 2)'(cap_q);
  assign end_taken  = accept && (in_i.operation == OpEnd) && !end_refuse;

  // first value bit lands on the lowest free stream bit: mirror the value
  assign rev      = {<<{in_i.data_value}};
  assign rsh      = LenW'(DataW) - LenW'(width_q);
  assign val      = rev >> rsh;
  assign acc      = AccW'(partial_q) | (AccW'(val) << fill);
  assign total    = LenW'(fill) + LenW'(width_q);
  assign nbytes   = 3'(total >> 3);
  assign acc_rest = acc >> {nbytes, 3'b000};

  always_comb begin
    err_job            = '0;
    err_job.last_sel   = '0;
    err_job.base_index = cursor_q[CursorW-1:3];
    err_job.err        = 1'b1;
  end

  always_comb begin
    push_o    = 1'b0;
    job_o     = err_job;
    cursor_d  = cursor_q;
    partial_d = partial_q;
    if (accept) begin
      case (in_i.operation)
        OpWrite: begin
          if (wr_refuse) begin
            push_o = 1'b1;
          end else begin
            push_o           = (nbytes != 3'd0);
            job_o.bytes      = acc[MaxBytes*8-1:0];
            job_o.last_sel   = ByteSelW'(nbytes - 3'd1);
            job_o.base_index = cursor_q[CursorW-1:3];
            job_o.err        = 1'b0;
            cursor_d         = end_pos[CursorW-1:0];
            partial_d        = acc_rest[PartialW-1:0];
          end
        end
        OpEnd: begin
          if (end_refuse) begin
            push_o = 1'b1;
          end else if (fill != 3'd0) begin
            push_o           = 1'b1;
            job_o.bytes      = '0;
            job_o.bytes[0]   = {1'b0, partial_q};
            job_o.last_sel   = '0;
            job_o.base_index = cursor_q[CursorW-1:3];
            job_o.err        = 1'b0;
            cursor_d         = round_pos[CursorW-1:0] & ~CursorW'(7);
            partial_d        = '0;
          end
        end
        OpRestart: begin
          cursor_d  = '0;
          partial_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q  <= '0;
      partial_q <= '0;
    end else begin
      cursor_q  <= cursor_d;
      partial_q <= partial_d;
    end
  end

  `FWBP_ASSERT_NEVER(a_partial_clean, (partial_q >> fill) != '0)
  `FWBP_ASSERT(a_end_aligns, end_taken |=> cursor_q[2:0] == 3'd0)

endmodule

// ===== hdl/fwbp_back.sv =====
// ---------------------------------------------------------------------------
// fwbp_back
// Emits each job's bytes via an output register, one per unstalled cycle.
// ---------------------------------------------------------------------------
`include "fixed_width_bit_packer_defines.svh"

module fwbp_back import fwbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_o
);

  job_t                job_q;
  logic                job_valid_q, job_valid_d;
  logic [ByteSelW-1:0] sent_q, sent_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q;
  logic                load_out;
  logic                last_byte;

  assign load_out  = job_valid_q && (!out_valid_q || out_ready_i);
  assign last_byte = (sent_q == job_q.last_sel);
  assign pop_o     = job_valid_i && (!job_valid_q || (load_out && last_byte));

  always_comb begin
    job_valid_d = job_valid_q;
    sent_d      = sent_q;
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      sent_d      = last_byte ? '0 : sent_q + 1'b1;
      if (last_byte) begin
        job_valid_d = 1'b0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      job_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      sent_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      sent_q      <= sent_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (load_out) begin
      out_q.out_byte       <= job_q.bytes[sent_q];
      out_q.byte_index     <= job_q.base_index + CapW'(sent_q);
      out_q.is_last        <= last_byte;
      out_q.overflow_error <= job_q.err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `FWBP_ASSERT_NEVER(a_sent_range, job_valid_q && sent_q > job_q.last_sel)

endmodule

// ===== hdl/fixed_width_bit_packer.sv =====
// ---------------------------------------------------------------------------
// fixed_width_bit_packer
// Packs fixed-width values into a byte stream, most significant value bit first.
// ---------------------------------------------------------------------------
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i         | in
//  request  | in_valid_i, in_ready_o, in_i             | in
//  result   | out_valid_o, out_ready_i, out_o          | out
//
// The front end takes one request per cycle while the two-entry job queue
// has room; write, end and restart update the cursor in that same cycle.
// The result side emits one byte per cycle while out_ready_i is high, so a
// write that completes n bytes yields n results (up to 4 at 32-bit width).
// A result passes the job queue, the job register and the output register.
// Reset clears cursor and queue at once; there is no clearing pass.
// A stalled result port fills the queue and then drops in_ready_o.
// ---------------------------------------------------------------------------
`include "fixed_width_bit_packer_defines.svh"

module fixed_width_bit_packer import fwbp_pkg::*; #(
  parameter int unsigned MaxValueBits = MaxValueBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_o
);

  logic push;
  job_t push_job;
  logic full;
  logic pop;
  logic job_valid;
  job_t pop_job;

  fwbp_front #(
    .MaxValueBits(MaxValueBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (full)
  );

  fwbp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .full_o    (full),
    .pop_i     (pop),
    .valid_o   (job_valid),
    .pop_job_o (pop_job)
  );

  fwbp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (pop_job),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: fixed-width bit packer testbench
// Drives write, end, restart and unused requests through the valid/ready
// request port under several limit value and capacity settings. A stream
// tracker mirrors the cursor and the partial byte, predicts every result
// byte or overflow flag, and checks the result port in order. Both sides
// idle at random; one phase stalls the result side long enough to back up
// the request port.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fwbp_pkg::*;

  localparam logic [1:0]  OpIgnored     = 2'd3;
  localparam int unsigned RandomItems   = 280;
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PrintLimit    = 40;

  // Mirrors the packer state and holds the bytes it still owes.
  class stream_tracker;
    logic [DataW-1:0] limit_value = 32'd255;
    int unsigned      capacity  = 4096;
    int unsigned      cursor    = 0;
    logic [6:0]       partial   = '0;
    out_item_t        owed_bytes[$];
    int unsigned      mismatches = 0;

    function void configure(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] value);
      if (idx == RegMaxValue) limit_value = value;
      else capacity = value[CapW-1:0];
    endfunction

    function int unsigned value_width();
      int unsigned n;
      logic [DataW-1:0] v;
      n = 0;
      v = limit_value;
      while (v != '0) begin
        v = v >> 1;
        n++;
      end
      if (n > MaxValueBitsDefault) n = MaxValueBitsDefault;
      if (n < 1) n = 1;
      return n;
    endfunction

    function void owe(logic [7:0] b, int unsigned idx, bit last, bit err);
      out_item_t r;
      r.out_byte       = b;
      r.byte_index     = CapW'(idx);
      r.is_last        = last;
      r.overflow_error = err;
      owed_bytes.push_back(r);
    endfunction

    function void note_request(in_item_t req);
      int unsigned w, fill, total, idx, fin, t;
      logic [63:0] acc;
      case (req.operation)
        OpWrite: begin
          w   = value_width();
          fin = cursor + w;
          if ((fin >> 3) >= capacity) begin
            owe(8'h00, cursor >> 3, 1'b1, 1'b1);
          end else begin
            fill  = cursor & 7;
            total = fill + w;
            idx   = cursor >> 3;
            acc   = {57'd0, partial};
            // msb of the value lands on the lowest free stream bit
            for (t = 0; t < w; t++) acc[fill + t] = req.data_value[w - 1 - t];
            while (total >= 8) begin
              owe(acc[7:0], idx, total < 16, 1'b0);
              idx++;
              acc   = acc >> 8;
              total -= 8;
            end
            partial = acc[6:0];
            cursor  = fin;
          end
        end
        OpEnd: begin
          if (((cursor + 7) >> 3) > capacity) begin
            owe(8'h00, cursor >> 3, 1'b1, 1'b1);
          end else if ((cursor & 7) != 0) begin
            owe({1'b0, partial}, cursor >> 3, 1'b1, 1'b0);
            partial = '0;
            cursor  = (cursor + 7) & ~32'd7;
          end
        end
        OpRestart: begin
          cursor  = 0;
          partial = '0;
        end
        default: ;
      endcase
    endfunction

    task log_mismatch(string what);
      if (mismatches < PrintLimit) $display("[%0t] MISMATCH %s", $realtime, what);
      mismatches++;
    endtask

    task check_byte(out_item_t got);
      out_item_t exp;
      if (owed_bytes.size() == 0) begin
        log_mismatch($sformatf("unexpected result %p", got));
        return;
      end
      exp = owed_bytes.pop_front();
      if (got.out_byte !== exp.out_byte)
        log_mismatch($sformatf("out_byte %h, want %h", got.out_byte, exp.out_byte));
      if (got.byte_index !== exp.byte_index)
        log_mismatch($sformatf("byte_index %0d, want %0d", got.byte_index,
                               exp.byte_index));
      if (got.is_last !== exp.is_last)
        log_mismatch($sformatf("is_last %b, want %b", got.is_last, exp.is_last));
      if (got.overflow_error !== exp.overflow_error)
        log_mismatch($sformatf("overflow_error %b, want %b", got.overflow_error,
                               exp.overflow_error));
    endtask

    function int unsigned pending();
      return owed_bytes.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [DataW-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  in_item_t           in_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_item_t          out_o;

  stream_tracker tracker = new();
  bit            sender_burst  = 1'b0;
  bit            hold_results  = 1'b0;

  fixed_width_bit_packer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic set_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    tracker.configure(idx, value);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_req(logic [1:0] op, logic [DataW-1:0] data);
    in_item_t    req;
    int unsigned gap;
    req.operation  = op;
    req.data_value = data;
    gap = sender_burst ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= req;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_request(req);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // Drop valid, let every owed byte arrive, then let the pipe go quiet.
  task automatic end_phase();
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic pick_config();
    int unsigned      k, nbits;
    logic [DataW-1:0] mv;
    logic [CapW-1:0]  cap;
    k = $urandom_range(0, 9);
    if (k == 0) mv = '0;
    else if (k == 1) mv = '1;
    else begin
      nbits = $urandom_range(1, 32);
      mv = ($urandom() >> (32 - nbits)) | (32'd1 << (nbits - 1));
    end
    k = $urandom_range(0, 9);
    if (k == 0) cap = 16'hFFFF;
    else if (k == 1) cap = CapW'($urandom_range(0, 2));
    else cap = CapW'($urandom_range(3, 48));
    if ($urandom_range(0, 3) != 0) set_reg(RegMaxValue, mv);
    // upper write data bits are junk for the capacity register
    set_reg(RegCapacity, {16'($urandom()), cap});
  endtask

  // Result side: random stalls, quiet stretches, and one long hold-off.
  initial begin : result_sink
    int unsigned gap, run;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_results) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_results = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
      out_ready_i <= 1'b1;
      // cut the run short as soon as a hold-off is requested
      repeat (run) begin
        @(posedge clk_i);
        if (hold_results) break;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_byte(out_o);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int unsigned done_items, phase, n, i, r;
    logic [1:0]  op;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_i        <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings: 8-bit values, ample room.
    send_req(OpWrite, 32'h0000_0000);
    send_req(OpWrite, 32'h0000_00FF);
    send_req(OpWrite, 32'hFFFF_FF5A);   // bits above the width are ignored
    send_req(OpEnd, 32'h0);             // on a boundary: nothing out
    send_req(OpIgnored, 32'hFFFF_FFFF);
    send_req(OpRestart, 32'h0);
    end_phase();

    // Zero limit value packs single bits.
    set_reg(RegMaxValue, 32'd0);
    send_req(OpWrite, 32'd1);
    send_req(OpWrite, 32'd0);
    send_req(OpWrite, 32'hFFFF_FFFF);
    send_req(OpEnd, 32'h0);
    send_req(OpEnd, 32'h0);
    send_req(OpWrite, 32'd1);
    send_req(OpWrite, 32'd1);
    end_phase();

    // Full 32-bit values on top of a partial byte: four bytes per write.
    set_reg(RegMaxValue, 32'hFFFF_FFFF);
    set_reg(RegCapacity, 32'd65535);
    send_req(OpWrite, 32'hFFFF_FFFF);
    send_req(OpWrite, 32'h1234_5678);
    send_req(OpWrite, 32'h8000_0001);
    end_phase();

    // Capacity lowered below the cursor, then one byte of room.
    set_reg(RegMaxValue, 32'd127);
    set_reg(RegCapacity, 32'd1);
    send_req(OpWrite, 32'h7F);          // refused
    send_req(OpEnd, 32'h0);             // refused, cursor mid-byte
    send_req(OpRestart, 32'h0);
    send_req(OpWrite, 32'h55);
    send_req(OpWrite, 32'h2A);          // refused
    send_req(OpEnd, 32'h0);
    end_phase();

    // Zero capacity: writes and an end past byte 0 refused, end at 0 silent.
    set_reg(RegCapacity, 32'd0);
    send_req(OpWrite, 32'h0);
    send_req(OpEnd, 32'h0);
    send_req(OpRestart, 32'h0);
    send_req(OpEnd, 32'h0);
    end_phase();

    done_items = 0;
    phase = 0;
    while (done_items < RandomItems) begin
      if (phase == 1) begin
        // Back up the request port behind a held result port.
        set_reg(RegMaxValue, 32'hFFFF_FFFF);
        set_reg(RegCapacity, 32'd65535);
        sender_burst = 1'b1;
        hold_results = 1'b1;
        for (i = 0; i < 24; i++) send_req(OpWrite, $urandom());
        done_items += 24;
        sender_burst = 1'b0;
      end else begin
        pick_config();
        sender_burst = ($urandom_range(0, 3) == 0);
        n = $urandom_range(20, 60);
        for (i = 0; i < n; i++) begin
          r = $urandom_range(0, 99);
          if (r < 72) op = OpWrite;
          else if (r < 84) op = OpEnd;
          else if (r < 93) op = OpRestart;
          else op = OpIgnored;
          send_req(op, $urandom());
          done_items++;
          if ($urandom_range(0, 49) == 0) begin
            in_valid_i <= 1'b0;
            wait_drained();
          end
        end
      end
      end_phase();
      phase++;
    end

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/fwbp_pkg.sv
hdl/fwbp_queue.sv
hdl/fwbp_front.sv
hdl/fwbp_back.sv
hdl/fixed_width_bit_packer.sv
verif/tb_top.sv
